[rtl/hdfb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdfb_pkg
// Shared types, codes and reset values of the half-duplex frame buffer.
// ----------------------------------------------------------------------------
package hdfb_pkg;

  // Default depth of the shared byte store
  localparam int HDFB_BUFF_DEPTH = 64;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RX_IDLE_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIVE_TICKS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_FRAME_LEN = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  RX_IDLE_TICKS_RST   = 8'd5;
  localparam logic [15:0] ALIVE_TICKS_RST     = 16'd2000;
  localparam logic [5:0]  SHORT_FRAME_LEN_RST = 6'd8;

  // Event codes carried in the action field
  localparam logic [2:0] ACT_RX_BYTE     = 3'd0;
  localparam logic [2:0] ACT_MS_TICK     = 3'd1;
  localparam logic [2:0] ACT_TX_APPEND   = 3'd2;
  localparam logic [2:0] ACT_TX_READY    = 3'd3;
  localparam logic [2:0] ACT_TX_COMPLETE = 3'd4;
  localparam logic [2:0] ACT_RELEASE     = 3'd5;

  // Input beat
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       driver_enable;
    logic       frame_ready;
    logic       short_frame;
    logic [5:0] rx_count;
    logic       link_alive;
  } out_item_t;

endpackage

[rtl/half_duplex_frame_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_duplex_frame_buffer
// Serial frame buffer with one byte store shared by receive and transmit,
// idle-timeout frame closing and a link-alive timer.
//
//   channel | ports                              | beat
//   --------+------------------------------------+-------------------------
//   input   | in_valid, in_stall, in_item        | one event (action, data)
//   result  | out_valid, out_stall, out_item     | one status/tx beat
//   config  | cfg_we, cfg_index, cfg_data        | one register write
//
// Each accepted event moves from the input register through one pass of
// event logic into the result register; the store read for a tx-ready event
// lands in the store's read register at the same edge.
// One event is accepted per cycle while the result side keeps up.
// Reset is synchronous; the store needs no clearing pass.
// A stalled result holds; input stalls only when both stages are full.
// ----------------------------------------------------------------------------
module half_duplex_frame_buffer #(
  parameter int BUFF_DEPTH = hdfb_pkg::HDFB_BUFF_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  hdfb_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output hdfb_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [hdfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hdfb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hdfb_pkg::*;

  localparam int AW = $clog2(BUFF_DEPTH);

  logic          s1_valid;
  in_item_t      s1_item;
  logic          adv;
  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [7:0]    st_wdata, st_rdata;
  out_item_t     res_nxt;
  logic          rd_sel_nxt;
  logic          out_valid_r;
  out_item_t     out_r;
  logic          rd_sel_r;

  // Advance the held beat when the result register is free
  assign adv = s1_valid && (!out_valid_r || !out_stall);

  hdfb_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  hdfb_ctrl #(
    .BUFF_DEPTH (BUFF_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .adv        (adv),
    .s1_item    (s1_item),
    .st_we      (st_we),
    .st_waddr   (st_waddr),
    .st_wdata   (st_wdata),
    .st_re      (st_re),
    .st_raddr   (st_raddr),
    .res_nxt    (res_nxt),
    .rd_sel_nxt (rd_sel_nxt)
  );

  hdfb_store #(
    .BUFF_DEPTH (BUFF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Hold the result beat until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r    <= res_nxt;
      rd_sel_r <= rd_sel_nxt;
    end
  end

  // Take the transmit byte from the store read register on a ready event
  always_comb begin
    out_item = out_r;
    if (rd_sel_r) begin
      out_item.tx_byte = st_rdata;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/hdfb_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdfb_in_reg
// Input register: captures one beat and holds it until the event logic
// advances it into the result register.
// ----------------------------------------------------------------------------
module hdfb_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hdfb_pkg::in_item_t in_item,
  input  logic              adv,
  output logic              s1_valid,
  output hdfb_pkg::in_item_t s1_item
);
  import hdfb_pkg::*;

  logic     s1_valid_r;
  in_item_t s1_item_r;

  // Stall while a held beat cannot move on
  assign in_stall = s1_valid_r && !adv;
  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

  // Load a new beat whenever the stage is empty or drains this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
  end

endmodule

[rtl/hdfb_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdfb_store
// Shared byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hdfb_store #(
  parameter int BUFF_DEPTH = hdfb_pkg::HDFB_BUFF_DEPTH
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(BUFF_DEPTH)-1:0] waddr,
  input  logic [7:0]                    wdata,
  input  logic                          re,
  input  logic [$clog2(BUFF_DEPTH)-1:0] raddr,
  output logic [7:0]                    rdata
);
  import hdfb_pkg::*;

  logic [7:0] mem [BUFF_DEPTH];
  logic [7:0] rdata_r;

  assign rdata = rdata_r;

  // Write and read; the read data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

[rtl/hdfb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdfb_ctrl
// Event logic: configuration registers, receive and transmit state, store
// access commands and the next result beat.
// ----------------------------------------------------------------------------
module hdfb_ctrl #(
  parameter int BUFF_DEPTH = hdfb_pkg::HDFB_BUFF_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [hdfb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hdfb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                adv,
  input  hdfb_pkg::in_item_t                  s1_item,
  output logic                                st_we,
  output logic [$clog2(BUFF_DEPTH)-1:0]       st_waddr,
  output logic [7:0]                          st_wdata,
  output logic                                st_re,
  output logic [$clog2(BUFF_DEPTH)-1:0]       st_raddr,
  output hdfb_pkg::out_item_t                 res_nxt,
  output logic                                rd_sel_nxt
);
  import hdfb_pkg::*;

  localparam int AW = $clog2(BUFF_DEPTH);
  localparam int CW = $clog2(BUFF_DEPTH + 1);
  localparam int LW = (AW > 6) ? AW : 6;
  localparam logic [AW-1:0] RX_LAST = AW'(BUFF_DEPTH - 1);
  localparam logic [CW-1:0] TX_TOP  = CW'(BUFF_DEPTH);

  // Configuration
  logic [7:0]  rx_idle_ticks_r;
  logic [15:0] alive_ticks_r;
  logic [5:0]  short_len_r;

  // Event state
  logic [AW-1:0] rx_fill_r, rx_fill_nxt, rx_inc;
  logic          closed_r, closed_nxt;
  logic          short_r, short_nxt;
  logic [7:0]    idle_r, idle_nxt;
  logic [15:0]   alive_r, alive_nxt;
  logic [CW-1:0] tx_fill_r, tx_fill_nxt;
  logic [CW-1:0] tx_sent_r, tx_sent_nxt;
  logic          active_r, active_nxt;
  logic          ready_en_r, ready_en_nxt;
  logic          armed_r, armed_nxt;
  logic          send;
  logic [7:0]    send_byte;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_idle_ticks_r <= RX_IDLE_TICKS_RST;
      alive_ticks_r   <= ALIVE_TICKS_RST;
      short_len_r     <= SHORT_FRAME_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RX_IDLE_TICKS:   rx_idle_ticks_r <= cfg_data[7:0];
        CFG_ALIVE_TICKS:     alive_ticks_r   <= cfg_data[15:0];
        CFG_SHORT_FRAME_LEN: short_len_r     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign rx_inc = rx_fill_r + 1'b1;

  // Decode one event into next state and store access
  always_comb begin
    rx_fill_nxt  = rx_fill_r;
    closed_nxt   = closed_r;
    short_nxt    = short_r;
    idle_nxt     = idle_r;
    alive_nxt    = alive_r;
    tx_fill_nxt  = tx_fill_r;
    tx_sent_nxt  = tx_sent_r;
    active_nxt   = active_r;
    ready_en_nxt = ready_en_r;
    armed_nxt    = armed_r;
    send         = 1'b0;
    send_byte    = 8'd0;
    rd_sel_nxt   = 1'b0;
    st_we        = 1'b0;
    st_waddr     = rx_fill_r;
    st_wdata     = s1_item.data;
    st_re        = 1'b0;
    st_raddr     = tx_sent_r[AW-1:0];

    unique case (s1_item.action)
      ACT_RX_BYTE: begin
        alive_nxt = alive_ticks_r;
        if (!closed_r) begin
          idle_nxt = rx_idle_ticks_r;
          if (rx_fill_r < RX_LAST) begin
            st_we       = adv;
            st_waddr    = rx_fill_r;
            rx_fill_nxt = rx_inc;
            if (LW'(rx_inc) == LW'(short_len_r)) begin
              short_nxt = 1'b1;
            end
            if (rx_inc == RX_LAST) begin
              closed_nxt = 1'b1;
            end
          end
        end
      end
      ACT_MS_TICK: begin
        if (idle_r != 8'd0) begin
          idle_nxt = idle_r - 8'd1;
          if (idle_r == 8'd1 && rx_fill_r != '0) begin
            closed_nxt = 1'b1;
          end
        end
        if (alive_r != 16'd0) begin
          alive_nxt = alive_r - 16'd1;
        end
      end
      ACT_TX_APPEND: begin
        if (!active_r) begin
          // Start a transmission and send the first byte right away
          active_nxt   = 1'b1;
          st_we        = adv;
          st_waddr     = '0;
          tx_fill_nxt  = CW'(1);
          tx_sent_nxt  = CW'(1);
          ready_en_nxt = 1'b1;
          send         = 1'b1;
          send_byte    = s1_item.data;
        end else if (tx_fill_r < TX_TOP) begin
          st_we       = adv;
          st_waddr    = tx_fill_r[AW-1:0];
          tx_fill_nxt = tx_fill_r + 1'b1;
        end
      end
      ACT_TX_READY: begin
        if (ready_en_r) begin
          if (tx_sent_r < tx_fill_r && tx_sent_r < TX_TOP) begin
            send        = 1'b1;
            rd_sel_nxt  = 1'b1;
            st_re       = adv;
            tx_sent_nxt = tx_sent_r + 1'b1;
          end else begin
            ready_en_nxt = 1'b0;
            armed_nxt    = 1'b1;
          end
        end
      end
      ACT_TX_COMPLETE: begin
        if (armed_r) begin
          active_nxt = 1'b0;
          armed_nxt  = 1'b0;
        end
      end
      ACT_RELEASE: begin
        rx_fill_nxt = '0;
        closed_nxt  = 1'b0;
        short_nxt   = 1'b0;
        idle_nxt    = 8'd0;
      end
      default: ;
    endcase
  end

  // Build the result beat from the updated state
  always_comb begin
    res_nxt.tx_valid      = send;
    res_nxt.tx_byte       = send_byte;
    res_nxt.driver_enable = active_nxt;
    res_nxt.frame_ready   = closed_nxt;
    res_nxt.short_frame   = short_nxt;
    res_nxt.rx_count      = 6'(rx_fill_nxt);
    res_nxt.link_alive    = (alive_nxt != 16'd0);
  end

  // Commit state when the beat advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_fill_r  <= '0;
      closed_r   <= 1'b0;
      short_r    <= 1'b0;
      idle_r     <= 8'd0;
      alive_r    <= 16'd0;
      tx_fill_r  <= '0;
      tx_sent_r  <= '0;
      active_r   <= 1'b0;
      ready_en_r <= 1'b0;
      armed_r    <= 1'b0;
    end else if (adv) begin
      rx_fill_r  <= rx_fill_nxt;
      closed_r   <= closed_nxt;
      short_r    <= short_nxt;
      idle_r     <= idle_nxt;
      alive_r    <= alive_nxt;
      tx_fill_r  <= tx_fill_nxt;
      tx_sent_r  <= tx_sent_nxt;
      active_r   <= active_nxt;
      ready_en_r <= ready_en_nxt;
      armed_r    <= armed_nxt;
    end
  end

endmodule

[test/hdfb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdfb_checker
// Watches the event, result and register ports of the frame buffer. Every
// accepted event runs through a cycle-free model of the shared store, the
// receive and transmit counters and both timers. The status beat it yields is
// queued and compared field by field with the next result beat.
// ----------------------------------------------------------------------------
module hdfb_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  hdfb_pkg::in_item_t              in_item,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  hdfb_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [hdfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hdfb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  import hdfb_pkg::*;

  localparam int DEPTH = HDFB_BUFF_DEPTH;

  // Mirror of the block state
  logic [7:0]  mem [DEPTH];
  int          rx_len;
  int          tx_len;
  int          tx_pos;
  logic        rx_done;
  logic        short_hit;
  logic        tx_busy;
  logic        ready_on;
  logic        complete_on;
  logic [7:0]  idle_cnt;
  logic [15:0] alive_cnt;

  // Mirror of the registers
  logic [7:0]  idle_reload;
  logic [15:0] alive_reload;
  logic [5:0]  short_len;

  out_item_t   status_q [$];
  int          fail_tally;

  // Apply one event to the mirror and build the status beat it yields
  task automatic apply_event(input in_item_t ev, output out_item_t res);
    res = '0;
    case (ev.action)
      ACT_RX_BYTE: begin
        alive_cnt = alive_reload;
        if (!rx_done) begin
          idle_cnt = idle_reload;
          if (rx_len < DEPTH - 1) begin
            mem[rx_len] = ev.data;
            rx_len++;
            if (rx_len == int'(short_len)) short_hit = 1'b1;
            if (rx_len == DEPTH - 1) rx_done = 1'b1;
          end
        end
      end
      ACT_MS_TICK: begin
        if (idle_cnt != 0) begin
          idle_cnt--;
          if (idle_cnt == 0 && rx_len > 0) rx_done = 1'b1;
        end
        if (alive_cnt != 0) alive_cnt--;
      end
      ACT_TX_APPEND: begin
        // First append opens a transmission and sends its byte at once
        if (!tx_busy) begin
          tx_busy     = 1'b1;
          mem[0]      = ev.data;
          tx_len      = 1;
          tx_pos      = 1;
          ready_on    = 1'b1;
          res.tx_valid = 1'b1;
          res.tx_byte  = ev.data;
        end else if (tx_len < DEPTH) begin
          mem[tx_len] = ev.data;
          tx_len++;
        end
      end
      ACT_TX_READY: begin
        if (ready_on) begin
          if (tx_pos < tx_len && tx_pos < DEPTH) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = mem[tx_pos];
            tx_pos++;
          end else begin
            ready_on    = 1'b0;
            complete_on = 1'b1;
          end
        end
      end
      ACT_TX_COMPLETE: begin
        if (complete_on) begin
          tx_busy     = 1'b0;
          complete_on = 1'b0;
        end
      end
      ACT_RELEASE: begin
        rx_len    = 0;
        rx_done   = 1'b0;
        short_hit = 1'b0;
        idle_cnt  = '0;
      end
      default: begin
      end
    endcase
    res.driver_enable = tx_busy;
    res.frame_ready   = rx_done;
    res.short_frame   = short_hit;
    res.rx_count      = rx_len[5:0];
    res.link_alive    = (alive_cnt != 0);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t next;
    if (!rst_n) begin
      foreach (mem[i]) mem[i] = '0;
      rx_len       = 0;
      tx_len       = 0;
      tx_pos       = 0;
      rx_done      = 1'b0;
      short_hit    = 1'b0;
      tx_busy      = 1'b0;
      ready_on     = 1'b0;
      complete_on  = 1'b0;
      idle_cnt     = '0;
      alive_cnt    = '0;
      idle_reload  = RX_IDLE_TICKS_RST;
      alive_reload = ALIVE_TICKS_RST;
      short_len    = SHORT_FRAME_LEN_RST;
      status_q.delete();
      fail_tally   = 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_RX_IDLE_TICKS:   idle_reload  = cfg_data[7:0];
          CFG_ALIVE_TICKS:     alive_reload = cfg_data[15:0];
          CFG_SHORT_FRAME_LEN: short_len    = cfg_data[5:0];
          default: begin
          end
        endcase
      end

      // Compare an accepted result beat with the oldest prediction
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          fail_tally++;
          if (fail_tally <= 10)
            $display("hdfb_checker: result beat with nothing pending: %p", out_item);
        end else begin
          want = status_q.pop_front();
          if (out_item.tx_valid      !== want.tx_valid      ||
              out_item.tx_byte       !== want.tx_byte       ||
              out_item.driver_enable !== want.driver_enable ||
              out_item.frame_ready   !== want.frame_ready   ||
              out_item.short_frame   !== want.short_frame   ||
              out_item.rx_count      !== want.rx_count      ||
              out_item.link_alive    !== want.link_alive) begin
            fail_tally++;
            if (fail_tally <= 10)
              $display("hdfb_checker: mismatch at %0t exp %p got %p",
                       $realtime, want, out_item);
          end
        end
      end

      // Predict the status beat of an accepted event
      if (in_valid && !in_stall) begin
        apply_event(in_item, next);
        status_q.push_back(next);
      end
    end
    mismatches  <= fail_tally;
    outstanding <= status_q.size();
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the frame buffer with receive frames, transmit messages, timer ticks
// and stray events under several register settings, with random gaps on the
// event side and random stalls on the result side. The checker beside the
// block predicts and compares every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import hdfb_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int sent;
  int gap_odds;
  int idle_setting;
  bit calm;

  half_duplex_frame_buffer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hdfb_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #400_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Stall the result side in random bursts, with quiet stretches between
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  // Present one event beat, after an optional gap, and hold it until accepted
  task automatic send_beat(input logic [2:0] act, input logic [7:0] dat);
    int pause;
    pause = 0;
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
      pause = $urandom_range(1, 14);
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{action: act, data: dat};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Drop valid and hold until every predicted beat has come back
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write all three registers back to back
  task automatic program_regs(input int idle_val, input int alive_val, input int short_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RX_IDLE_TICKS;
    cfg_data  <= 16'(idle_val);
    @(posedge clk);
    cfg_index <= CFG_ALIVE_TICKS;
    cfg_data  <= 16'(alive_val);
    @(posedge clk);
    cfg_index <= CFG_SHORT_FRAME_LEN;
    cfg_data  <= 16'(short_val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    idle_setting = idle_val;
  endtask

  // Receive a frame, let the line go quiet, and usually release it
  task automatic rx_frame;
    int n;
    int k;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) send_beat(ACT_MS_TICK, 8'($urandom_range(0, 255)));
      send_beat(ACT_RX_BYTE, 8'($urandom_range(0, 255)));
    end
    if (idle_setting == 0)
      k = $urandom_range(1, 4);
    else
      k = ((idle_setting > 10) ? 10 : idle_setting) - 1 + $urandom_range(0, 2);
    repeat (k) send_beat(ACT_MS_TICK, 8'($urandom_range(0, 255)));
    // A closed frame left unreleased makes later bytes drop
    if ($urandom_range(0, 3) != 0) send_beat(ACT_RELEASE, 8'($urandom_range(0, 255)));
  endtask

  // Append a message, drain it with ready events, then complete
  task automatic tx_message;
    int m;
    int r;
    m = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
    repeat (m) send_beat(ACT_TX_APPEND, 8'($urandom_range(0, 255)));
    r = ((m > HDFB_BUFF_DEPTH) ? HDFB_BUFF_DEPTH : m) + $urandom_range(0, 2);
    repeat (r) send_beat(ACT_TX_READY, 8'($urandom_range(0, 255)));
    // Appends after the drain are stored while room remains but not sent
    if ($urandom_range(0, 4) == 0) send_beat(ACT_TX_APPEND, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) != 0) send_beat(ACT_TX_COMPLETE, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 5) == 0) send_beat(ACT_TX_COMPLETE, 8'($urandom_range(0, 255)));
  endtask

  // Interleave receive and transmit traffic on the shared store
  task automatic mixed_traffic;
    logic [2:0] pick;
    repeat (20) begin
      case ($urandom_range(0, 3))
        0:       pick = ACT_RX_BYTE;
        1:       pick = ACT_MS_TICK;
        2:       pick = ACT_TX_APPEND;
        default: pick = ACT_TX_READY;
      endcase
      send_beat(pick, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int count);
    int target;
    int pick;
    target = sent + count;
    while (sent < target) begin
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
      pick = $urandom_range(0, 99);
      if (pick < 35)
        rx_frame();
      else if (pick < 70)
        tx_message();
      else if (pick < 85)
        mixed_traffic();
      else
        repeat ($urandom_range(1, 6))
          send_beat(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    calm         = 1'b0;
    sent         = 0;
    gap_odds     = 4;
    idle_setting = RX_IDLE_TICKS_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: data extremes, every event, unarmed events, spare codes
    send_beat(ACT_RX_BYTE, 8'h00);
    send_beat(ACT_RX_BYTE, 8'hFF);
    send_beat(ACT_MS_TICK, 8'h00);
    send_beat(ACT_TX_APPEND, 8'hFF);
    send_beat(ACT_TX_APPEND, 8'h00);
    send_beat(ACT_TX_APPEND, 8'h5A);
    send_beat(ACT_TX_READY, 8'h00);
    send_beat(ACT_TX_READY, 8'h00);
    send_beat(ACT_TX_READY, 8'h00);
    send_beat(ACT_TX_READY, 8'hFF);
    send_beat(ACT_TX_COMPLETE, 8'h00);
    send_beat(ACT_TX_COMPLETE, 8'hFF);
    send_beat(ACT_RELEASE, 8'h00);
    send_beat(3'd6, 8'hA5);
    send_beat(3'd7, 8'h5A);
    send_beat(ACT_MS_TICK, 8'hFF);
    // Idle timeout closes a one-byte frame
    send_beat(ACT_RX_BYTE, 8'hA5);
    repeat (5) send_beat(ACT_MS_TICK, 8'h00);
    send_beat(ACT_RELEASE, 8'hFF);
    drain();

    // Lowest settings
    program_regs(1, 1, 1);
    run_random(130);
    drain();

    // Highest settings
    program_regs(255, 65535, 63);
    run_random(130);
    drain();

    // Zero disables the idle timeout and the short-frame flag
    program_regs(0, 0, 0);
    run_random(110);
    drain();

    // Moderate settings, ending without gaps or stalls
    program_regs($urandom_range(2, 6), $urandom_range(3, 40), $urandom_range(2, 20));
    run_random(100);
    calm = 1'b1;
    run_random(60);
    drain();

    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
